// ===== rtl/linear_interp_resampler_macros.svh =====
// Assertion macros for the linear interpolation resampler checker.
`ifndef LINEAR_INTERP_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_MACROS_SVH

// implication in the same cycle
`define LIR_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lir assertion failed");

// implication in the next cycle
`define LIR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lir assertion failed");

`endif

// ===== rtl/lir_pkg.sv =====
// Shared types and constants of the linear interpolation resampler.
package lir_pkg;

    localparam int STEP_BITS = 21;
    localparam int FRAC_BITS = 16;
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1) << FRAC_BITS;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic span_final;
        logic has_tail;
        logic eos_item;
    } lir_flags_t;

endpackage

// ===== rtl/lir_queue.sv =====
// Small span queue between the front and back parts.
module lir_queue
    import lir_pkg::*;
#(
    parameter int WIDTH = 51
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = store_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/lir_front.sv =====
// Front part: takes input items and turns them into span jobs.
module lir_front
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   last_sample,
    output logic                   push,
    output logic [SAMPLE_BITS-1:0] push_a,
    output logic [SAMPLE_BITS-1:0] push_b,
    output lir_flags_t             push_flags,
    input  logic                   queue_full
);

    logic                   have_prev_reg;
    logic                   have_prev_next;
    logic [SAMPLE_BITS-1:0] prev_reg;
    logic [SAMPLE_BITS-1:0] prev_next;
    logic                   tail_pend_reg;
    logic                   tail_pend_next;
    logic [SAMPLE_BITS-1:0] tail_smp_reg;
    logic [SAMPLE_BITS-1:0] tail_smp_next;
    logic                   accept;

    assign in_ready = !tail_pend_reg && !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        tail_pend_next = tail_pend_reg;
        tail_smp_next  = tail_smp_reg;
        push           = 1'b0;
        push_a         = prev_reg;
        push_b         = in_sample;
        push_flags     = '{span_final: !last_sample, has_tail: last_sample,
                           eos_item: last_sample};
        if (tail_pend_reg)
        begin
            // hold sample of the final span
            push_a         = tail_smp_reg;
            push_b         = tail_smp_reg;
            push_flags     = '{span_final: 1'b1, has_tail: 1'b0, eos_item: 1'b1};
            push           = !queue_full;
            tail_pend_next = queue_full;
        end
        else if (accept)
        begin
            push = have_prev_reg;
            if (last_sample)
            begin
                tail_pend_next = 1'b1;
                tail_smp_next  = in_sample;
                have_prev_next = 1'b0;
                prev_next      = '0;
            end
            else
            begin
                have_prev_next = 1'b1;
                prev_next      = in_sample;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            tail_pend_reg <= 1'b0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
            prev_reg      <= prev_next;
            tail_pend_reg <= tail_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_smp_reg <= tail_smp_next;
    end

endmodule

// ===== rtl/lir_back.sv =====
// Back part: phase accumulator, interpolation pipeline and output register.
module lir_back
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS  = 24,
    parameter int MAX_UPSAMPLE = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [STEP_BITS-1:0]   phase_step,
    input  logic                   job_valid,
    input  logic [SAMPLE_BITS-1:0] job_a,
    input  logic [SAMPLE_BITS-1:0] job_b,
    input  lir_flags_t             job_flags,
    output logic                   job_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic                   last_of_run,
    output logic                   end_of_stream
);

    localparam int PH_W   = (STEP_BITS > FRAC_BITS) ? STEP_BITS : FRAC_BITS;
    localparam int SUM_W  = ((STEP_BITS > FRAC_BITS + 1) ? STEP_BITS : FRAC_BITS + 1) + 1;
    localparam int CNT_W  = $clog2(MAX_UPSAMPLE + 1);
    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
    localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0] TWO = SUM_W'(1) << (FRAC_BITS + 1);
    localparam logic [SUM_W-1:0] MIN_STEP =
        SUM_W'(((1 << FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE);
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    logic [PH_W-1:0]               phase_reg;
    logic [PH_W-1:0]               phase_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic signed [PROD_W-1:0]      s1_prod_reg;
    logic [SAMPLE_BITS-1:0]        s1_a_reg;
    logic                          s1_lor_reg;
    logic                          s1_eos_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [SAMPLE_BITS-1:0]        out_sample_reg;
    logic                          lor_reg;
    logic                          eos_reg;

    logic [SUM_W-1:0]              phase_ext;
    logic [SUM_W-1:0]              step_raw;
    logic [SUM_W-1:0]              step_eff;
    logic [SUM_W-1:0]              nxt;
    logic                          in_span;
    logic                          span_end;
    logic                          run_last;
    logic                          s1_load;
    logic                          s2_load;
    logic                          issue;
    logic                          skip;
    logic                          stream_done;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      rnd;
    logic signed [PROD_W-1:0]      quot;
    logic [SAMPLE_BITS-1:0]        out_sample_next;

    assign phase_ext   = SUM_W'(phase_reg);
    assign step_raw    = SUM_W'(phase_step);
    assign step_eff    = (step_raw < MIN_STEP) ? MIN_STEP : step_raw;
    assign nxt         = phase_ext + step_eff;
    assign in_span     = (phase_ext < ONE);
    assign span_end    = (nxt >= ONE) || (count_reg == CNT_W'(MAX_UPSAMPLE - 1));
    // the final span of a marked item is empty when the next phase passes two periods
    assign run_last    = span_end && (job_flags.span_final ||
                                      (job_flags.has_tail && (nxt >= TWO)));
    assign stream_done = job_flags.span_final && job_flags.eos_item;

    assign s2_load = !out_valid_reg || out_ready;
    assign s1_load = !s1_valid_reg || s2_load;
    assign issue   = job_valid && in_span && s1_load;
    assign skip    = job_valid && !in_span;
    assign job_pop = skip || (issue && span_end);

    assign diff   = $signed({job_b[SAMPLE_BITS-1], job_b}) - $signed({job_a[SAMPLE_BITS-1], job_a});
    assign frac_s = $signed({1'b0, phase_reg[FRAC_BITS-1:0]});
    assign prod   = diff * frac_s;

    assign rnd             = s1_prod_reg + $signed(HALF);
    assign quot            = rnd >>> FRAC_BITS;
    assign out_sample_next = s1_a_reg + quot[SAMPLE_BITS-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (skip)
        begin
            phase_next = PH_W'(phase_ext - ONE);
            count_next = '0;
            if (stream_done)
            begin
                phase_next = '0;
            end
        end
        else if (issue)
        begin
            if (span_end)
            begin
                count_next = '0;
                phase_next = (nxt >= ONE) ? PH_W'(nxt - ONE) : '0;
                if (stream_done)
                begin
                    phase_next = '0;
                end
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                phase_next = PH_W'(nxt);
            end
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_load ? issue : s1_valid_reg;
        out_valid_next = s2_load ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_prod_reg <= prod;
            s1_a_reg    <= job_a;
            s1_lor_reg  <= run_last;
            s1_eos_reg  <= run_last && job_flags.eos_item;
        end
        if (s2_load)
        begin
            out_sample_reg <= out_sample_next;
            lor_reg        <= s1_lor_reg;
            eos_reg        <= s1_eos_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_sample    = out_sample_reg;
    assign last_of_run   = lor_reg;
    assign end_of_stream = eos_reg;

endmodule

// ===== rtl/linear_interp_resampler.sv =====
// Linear interpolation resampler top level.
// One channel of signed samples in, linearly interpolated samples out at the rate
// set by cfg_data (source over target rate, FRAC_BITS fraction bits, reset 1.0).
// The front accepts an item whenever the four-entry span queue has room; an item
// marked last holds off the next item until its tail span is queued. The back's
// phase accumulator produces one result per cycle while the output side takes
// them. It steps once per result and once for each span that holds no output
// position; a span gives up to MAX_UPSAMPLE results, and an item marked last also
// has a tail span with its own results. Each result passes a multiply stage, then
// is rounded into the output register. Write cfg_data only while the block is idle.
module linear_interp_resampler
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS  = 24,
    parameter int MAX_UPSAMPLE = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [STEP_BITS-1:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   last_sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic                   last_of_run,
    output logic                   end_of_stream
);

    localparam int FLAG_W = $bits(lir_flags_t);
    localparam int JOB_W  = 2 * SAMPLE_BITS + FLAG_W;

    logic [STEP_BITS-1:0]   phase_step_reg;
    logic [STEP_BITS-1:0]   phase_step_next;
    logic                   push;
    logic [SAMPLE_BITS-1:0] push_a;
    logic [SAMPLE_BITS-1:0] push_b;
    lir_flags_t             push_flags;
    logic                   queue_full;
    logic                   job_valid;
    logic [JOB_W-1:0]       job_data;
    logic                   job_pop;
    logic [SAMPLE_BITS-1:0] job_a;
    logic [SAMPLE_BITS-1:0] job_b;
    lir_flags_t             job_flags;

    assign cfg_ready       = 1'b1;
    assign phase_step_next = (cfg_valid && cfg_ready) ? cfg_data : phase_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= STEP_RESET;
        end
        else
        begin
            phase_step_reg <= phase_step_next;
        end
    end

    lir_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_sample   (in_sample),
        .last_sample (last_sample),
        .push        (push),
        .push_a      (push_a),
        .push_b      (push_b),
        .push_flags  (push_flags),
        .queue_full  (queue_full)
    );

    lir_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_flags, push_a, push_b}),
        .full       (queue_full),
        .pop        (job_pop),
        .head_valid (job_valid),
        .head_data  (job_data)
    );

    assign job_flags = lir_flags_t'(job_data[JOB_W-1 -: FLAG_W]);
    assign job_a     = job_data[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
    assign job_b     = job_data[SAMPLE_BITS-1:0];

    lir_back #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .phase_step    (phase_step_reg),
        .job_valid     (job_valid),
        .job_a         (job_a),
        .job_b         (job_b),
        .job_flags     (job_flags),
        .job_pop       (job_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_sample    (out_sample),
        .last_of_run   (last_of_run),
        .end_of_stream (end_of_stream)
    );

endmodule

// ===== rtl/lir_checker.sv =====
// Port-level checker for the linear interpolation resampler, with its bind.
`include "linear_interp_resampler_macros.svh"

module lir_checker
#(
    parameter int SAMPLE_BITS = 24
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   last_sample,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] out_sample,
    input logic                   last_of_run,
    input logic                   end_of_stream
);

    // stream end is always also the end of its item's run
    `LIR_ASSERT_SAME(a_eos_run, clk, rst_n, out_valid && end_of_stream, last_of_run)

    // a last item queues its tail span before the next item is taken
    `LIR_ASSERT_NEXT(a_tail_gap, clk, rst_n, in_valid && in_ready && last_sample, !in_ready)

    // stalled item holds
    `LIR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_sample) && $stable(last_of_run) && $stable(end_of_stream))

endmodule

bind linear_interp_resampler lir_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lir_checker (.*);
